// File: rtl/ae_pkg.sv
package ae_pkg;

	localparam int ROOT_STEPS = 32;
	localparam int LOG_STEPS  = 30;
	localparam logic [28:0] LN2_Q29 = 29'd372130559;

	typedef struct packed {
		logic signed [31:0] x_value;
		logic               last_in;
	} in_t;

	typedef struct packed {
		logic signed [20:0] y_value;
		logic               last_out;
	} out_t;

	// sideband that rides along every stage
	typedef struct packed {
		logic valid;
		logic last;
		logic neg;
	} ctrl_t;

endpackage

// File: rtl/ae_root_step.sv
module ae_root_step #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  ae_pkg::ctrl_t ctrl_in,
	input  logic [63:0]   n_in,
	input  logic [63:0]   res_in,
	input  logic [31:0]   a_in,
	input  logic [3:0]    m_in,
	output ae_pkg::ctrl_t ctrl_out,
	output logic [63:0]   n_out,
	output logic [63:0]   res_out,
	output logic [31:0]   a_out,
	output logic [3:0]    m_out
);
	import ae_pkg::*;

	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic [63:0] trial;
	logic        fits;

	assign trial = res_in + BIT;
	assign fits  = (n_in >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_out <= '0;
		end else if (en) begin
			ctrl_out <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_out   <= fits ? (n_in - trial) : n_in;
			res_out <= fits ? ((res_in >> 1) + BIT) : (res_in >> 1);
			a_out   <= a_in;
			m_out   <= m_in;
		end
	end

endmodule

// File: rtl/ae_sq_step.sv
module ae_sq_step #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  ae_pkg::ctrl_t ctrl_in,
	input  logic [30:0]   z_in,
	input  logic [29:0]   frac_in,
	input  logic [5:0]    e_in,
	output ae_pkg::ctrl_t ctrl_out,
	output logic [30:0]   z_out,
	output logic [29:0]   frac_out,
	output logic [5:0]    e_out
);
	import ae_pkg::*;

	localparam int FB = 29 - STEP;

	logic [61:0] zz;
	logic [31:0] t;
	logic [29:0] frac_nx;

	always_comb begin
		zz = z_in * z_in;
		t  = zz[61:30];
		frac_nx = frac_in;
		frac_nx[FB] = t[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_out <= '0;
		end else if (en) begin
			ctrl_out <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_out    <= t[31] ? t[31:1] : t[30:0];
			frac_out <= frac_nx;
			e_out    <= e_in;
		end
	end

endmodule

// File: rtl/asinh_elementwise_unit.sv
// Throughput: one transaction per cycle while the output is not stalled; the whole pipeline advances together.
// Depth is set by the 32 square-root digit stages and 30 log2 squaring stages.
// in_ready drops only while a result is held at the output and out_ready is low.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data is not reset.
module asinh_elementwise_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ae_pkg::in_t  in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output ae_pkg::out_t out_data
);
	import ae_pkg::*;

	logic adv;

	ctrl_t       c_s1, c_s2, c_s3, c_s4;
	logic [31:0] a_s1, a_s2, a_s3, a_s4;
	logic [63:0] r_s2, r_s3, n_s4;
	logic [3:0]  m_s3, m_s4;

	ctrl_t       rc   [0:ROOT_STEPS];
	logic [63:0] rn   [0:ROOT_STEPS];
	logic [63:0] rres [0:ROOT_STEPS];
	logic [31:0] ra   [0:ROOT_STEPS];
	logic [3:0]  rm   [0:ROOT_STEPS];

	ctrl_t       c_s37, c_s38, c_s39;
	logic [47:0] v_s37, v_s38;
	logic [3:0]  m_s37, m_s38;
	logic [5:0]  p_s38;
	logic [30:0] z_s39;
	logic [5:0]  e_s39;

	ctrl_t       lc [0:LOG_STEPS];
	logic [30:0] lz [0:LOG_STEPS];
	logic [29:0] lf [0:LOG_STEPS];
	logic [5:0]  le [0:LOG_STEPS];

	ctrl_t       c_s70, c_s71, c_s72;
	logic [58:0] plo_s70;
	logic [34:0] phi_s70;
	logic [20:0] mag_s71;
	out_t        o_s72;

	logic [6:0]  lz_r;
	logic [5:0]  p_v;
	logic [65:0] acc;

	assign adv       = !c_s72.valid || out_ready;
	assign in_ready  = adv;
	assign out_valid = c_s72.valid;
	assign out_data  = o_s72;

	// leading zeros of r, leading one of v, and the rounded sum of the ln2 products
	always_comb begin
		lz_r = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (r_s2[i]) lz_r = 7'(63 - i);
		end
		p_v = '0;
		for (int i = 0; i < 48; i++) begin
			if (v_s37[i]) p_v = 6'(i);
		end
		acc = {1'b0, phi_s70, 30'b0} + {7'b0, plo_s70} + (66'd1 << 42);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1  <= '0;
			c_s2  <= '0;
			c_s3  <= '0;
			c_s4  <= '0;
			c_s37 <= '0;
			c_s38 <= '0;
			c_s39 <= '0;
			c_s70 <= '0;
			c_s71 <= '0;
			c_s72 <= '0;
		end else if (adv) begin
			c_s1  <= '{valid: in_valid, last: in_data.last_in, neg: in_data.x_value[31]};
			c_s2  <= c_s1;
			c_s3  <= c_s2;
			c_s4  <= c_s3;
			c_s37 <= rc[ROOT_STEPS];
			c_s38 <= c_s37;
			c_s39 <= c_s38;
			c_s70 <= lc[LOG_STEPS];
			c_s71 <= c_s70;
			c_s72 <= c_s71;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= in_data.x_value[31] ? (32'd0 - in_data.x_value) : in_data.x_value;
			a_s2 <= a_s1;
			r_s2 <= (64'(a_s1) * 64'(a_s1)) + (64'd1 << 32);
			a_s3 <= a_s2;
			r_s3 <= r_s2;
			m_s3 <= (lz_r >= 7'd30) ? 4'd15 : 4'(lz_r >> 1);
			a_s4 <= a_s3;
			m_s4 <= m_s3;
			n_s4 <= r_s3 << {m_s3, 1'b0};

			v_s37 <= ({16'b0, ra[ROOT_STEPS]} << rm[ROOT_STEPS])
				+ {16'b0, rres[ROOT_STEPS][31:0]};
			m_s37 <= rm[ROOT_STEPS];
			v_s38 <= v_s37;
			m_s38 <= m_s37;
			p_s38 <= p_v;
			z_s39 <= (p_s38 >= 6'd30) ? 31'(v_s38 >> (p_s38 - 6'd30))
				: 31'(v_s38 << (6'd30 - p_s38));
			e_s39 <= 6'(p_s38 - 6'd16 - {2'b0, m_s38});

			plo_s70 <= lf[LOG_STEPS] * LN2_Q29;
			phi_s70 <= le[LOG_STEPS] * LN2_Q29;
			mag_s71 <= acc[63:43];
			o_s72.y_value  <= c_s71.neg ? (21'd0 - mag_s71) : mag_s71;
			o_s72.last_out <= c_s71.last;
		end
	end

	assign rc[0]   = c_s4;
	assign rn[0]   = n_s4;
	assign rres[0] = '0;
	assign ra[0]   = a_s4;
	assign rm[0]   = m_s4;

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		ae_root_step #(.STEP(k)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.ctrl_in  (rc[k]),
			.n_in     (rn[k]),
			.res_in   (rres[k]),
			.a_in     (ra[k]),
			.m_in     (rm[k]),
			.ctrl_out (rc[k+1]),
			.n_out    (rn[k+1]),
			.res_out  (rres[k+1]),
			.a_out    (ra[k+1]),
			.m_out    (rm[k+1])
		);
	end

	assign lc[0] = c_s39;
	assign lz[0] = z_s39;
	assign lf[0] = '0;
	assign le[0] = e_s39;

	for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
		ae_sq_step #(.STEP(k)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.ctrl_in  (lc[k]),
			.z_in     (lz[k]),
			.frac_in  (lf[k]),
			.e_in     (le[k]),
			.ctrl_out (lc[k+1]),
			.z_out    (lz[k+1]),
			.frac_out (lf[k+1]),
			.e_out    (le[k+1])
		);
	end

endmodule

// File: rtl/ae_checker.sv
module ae_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input ae_pkg::in_t  in_data,
	input logic         out_valid,
	input logic         out_ready,
	input ae_pkg::out_t out_data
);
	import ae_pkg::*;

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// pipeline only stalls on a blocked output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output backpressure");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.y_value <= 21'sd727100) && (out_data.y_value >= -21'sd727100))
		else $error("result magnitude out of range");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output empty");

endmodule

bind asinh_elementwise_unit ae_checker u_ae_checker (.*);
